[rtl/jpcr_pkg.sv]
// ----------------------------------------------------------------------------
// jpcr_pkg
// shared types, constants and fixed-point helpers of the pivot rotation core
// ----------------------------------------------------------------------------
package jpcr_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned IDX_W        = 6;
  localparam int unsigned MAX_ROWS_DEF = 64;

  // 1.0 in q1.30
  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_BAD,
    ST_RD_P,
    ST_RD_Q,
    ST_LOAD,
    ST_DIFF,
    ST_MUL_DD,
    ST_MUL_CC,
    ST_TEST,
    ST_MUL_C2,
    ST_MUL_D2,
    ST_SQ1_GO,
    ST_SQ1_WT,
    ST_DIV1_GO,
    ST_DIV1_WT,
    ST_MUL_TM,
    ST_SQ2_GO,
    ST_SQ2_WT,
    ST_DIV2_GO,
    ST_DIV2_WT,
    ST_MUL_TC,
    ST_SV,
    ST_M_CC,
    ST_M_SS,
    ST_M_SC,
    ST_SC2,
    ST_NP0,
    ST_NP1,
    ST_NP2,
    ST_NP3,
    ST_NQ0,
    ST_NQ1,
    ST_NQ2,
    ST_NQ3,
    ST_E_RD,
    ST_E_M0,
    ST_E_M1,
    ST_E_M2,
    ST_E_M3,
    ST_E_M4,
    ST_E_OUT
  } step_e;

  typedef struct packed {
    step_e            step;
    logic             wr_en;
    logic [IDX_W-1:0] row;
    logic             ovr_p;
    logic             ovr_q;
    logic             bad;
    logic             last_row;
  } cmd_t;

  typedef struct packed {
    logic rot;
    logic u_zero;
    logic sq_done;
    logic div_done;
  } status_t;

  // floor(x / 2^30 + 1/2)
  function automatic logic signed [37:0] rescale30(input logic signed [67:0] x);
    logic signed [67:0] y;
    y = x + 68'sd536870912;
    return y[67:30];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [37:0] x);
    logic signed [31:0] r;
    if (x > 38'sd2147483647) r = 32'sh7fff_ffff;
    else if (x < -38'sd2147483648) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

[rtl/jpcr_isqrt.sv]
// ----------------------------------------------------------------------------
// jpcr_isqrt
// 64-bit integer square root, one bit pair per cycle
// ----------------------------------------------------------------------------
module jpcr_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] arg_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] v_q, v_d, r_q, r_d, b_q, b_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        run_q, run_d, done_q, done_d;
  logic [63:0] rb;

  always_comb begin
    v_d    = v_q;
    r_d    = r_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    rb     = r_q + b_q;
    if (start_i) begin
      v_d   = arg_i;
      r_d   = '0;
      b_d   = 64'h4000_0000_0000_0000;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (v_q >= rb) begin
        v_d = v_q - rb;
        r_d = (r_q >> 1) + b_q;
      end else begin
        r_d = r_q >> 1;
      end
      b_d   = b_q >> 2;
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    r_q <= r_d;
    b_q <= b_d;
  end

  assign done_o = done_q;
  assign root_o = r_q[31:0];

endmodule

[rtl/jpcr_div.sv]
// ----------------------------------------------------------------------------
// jpcr_div
// unsigned 64 by 34 bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module jpcr_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [33:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);

  logic [63:0] num_q, num_d, quo_q, quo_d;
  logic [33:0] den_q, den_d, rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        run_q, run_d, done_q, done_d;
  logic [34:0] rem_s;

  always_comb begin
    num_d  = num_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    rem_s  = {rem_q, num_q[63]};
    if (start_i) begin
      num_d = num_i;
      den_d = den_i;
      rem_d = '0;
      quo_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (rem_s >= {1'b0, den_q}) begin
        rem_d = 34'(rem_s - {1'b0, den_q});
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = rem_s[33:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      num_d = num_q << 1;
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q[31:0];

endmodule

[rtl/jpcr_datapath.sv]
// ----------------------------------------------------------------------------
// jpcr_datapath
// column stores, shared multiplier and accumulator, rotation registers
// ----------------------------------------------------------------------------
module jpcr_datapath #(
  parameter int unsigned MAX_ROWS = jpcr_pkg::MAX_ROWS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  jpcr_pkg::cmd_t          cmd_i,
  output jpcr_pkg::status_t       status_o,
  input  logic signed [31:0]      p_value_i,
  input  logic signed [31:0]      q_value_i,
  output logic signed [31:0]      p_updated_o,
  output logic signed [31:0]      q_updated_o,
  output logic signed [31:0]      cos_value_o,
  output logic signed [31:0]      sin_value_o,
  output logic [jpcr_pkg::IDX_W-1:0] row_index_o,
  output logic                    bad_pair_o,
  output logic                    last_result_o
);

  localparam int unsigned AW = $clog2(MAX_ROWS);

  logic signed [31:0] p_mem [MAX_ROWS];
  logic signed [31:0] q_mem [MAX_ROWS];
  logic signed [31:0] rd_p_q, rd_q_q;
  logic               rd_en;
  logic [AW-1:0]      addr;

  logic signed [31:0] app_q, apq_q, aqq_q;
  logic [32:0]        mc_q, md_q;
  logic               neg_q;
  logic [30:0]        ddsh_q;
  logic [33:0]        u_q;
  logic [31:0]        tm_q, sq_q;
  logic signed [31:0] c_q, s_q, cc_q, ss_q, sc2_q, newpp_q, newqq_q, pu_q;
  logic signed [67:0] prod_q, acc_q;
  logic signed [33:0] op_a, op_b;
  logic signed [67:0] prod_d;

  logic signed [32:0] cdif, ddif;
  logic [31:0]        sv;
  logic [63:0]        sv_t;

  logic        sq_start, div_start, sq_done, div_done;
  logic [63:0] sq_arg, div_num;
  logic [33:0] div_den;
  logic [31:0] sq_root, div_quo;
  logic        rot;

  assign addr  = cmd_i.row[AW-1:0];
  assign rd_en = (cmd_i.step == jpcr_pkg::ST_RD_P) || (cmd_i.step == jpcr_pkg::ST_RD_Q) ||
                 (cmd_i.step == jpcr_pkg::ST_E_RD);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      p_mem[addr] <= p_value_i;
      q_mem[addr] <= q_value_i;
    end
    if (rd_en) begin
      rd_p_q <= p_mem[addr];
      rd_q_q <= q_mem[addr];
    end
  end

  // multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.step)
      jpcr_pkg::ST_MUL_DD, jpcr_pkg::ST_MUL_D2: begin
        op_a = $signed({1'b0, md_q});
        op_b = $signed({1'b0, md_q});
      end
      jpcr_pkg::ST_MUL_CC, jpcr_pkg::ST_MUL_C2: begin
        op_a = $signed({1'b0, mc_q});
        op_b = $signed({1'b0, mc_q});
      end
      jpcr_pkg::ST_MUL_TM: begin
        op_a = $signed({2'b0, tm_q});
        op_b = $signed({2'b0, tm_q});
      end
      jpcr_pkg::ST_MUL_TC: begin
        op_a = $signed({2'b0, tm_q});
        op_b = 34'(c_q);
      end
      jpcr_pkg::ST_M_CC: begin op_a = 34'(c_q);   op_b = 34'(c_q);   end
      jpcr_pkg::ST_M_SS: begin op_a = 34'(s_q);   op_b = 34'(s_q);   end
      jpcr_pkg::ST_M_SC: begin op_a = 34'(s_q);   op_b = 34'(c_q);   end
      jpcr_pkg::ST_NP0:  begin op_a = 34'(cc_q);  op_b = 34'(app_q); end
      jpcr_pkg::ST_NP1:  begin op_a = 34'(sc2_q); op_b = 34'(apq_q); end
      jpcr_pkg::ST_NP2:  begin op_a = 34'(ss_q);  op_b = 34'(aqq_q); end
      jpcr_pkg::ST_NP3:  begin op_a = 34'(ss_q);  op_b = 34'(app_q); end
      jpcr_pkg::ST_NQ0:  begin op_a = 34'(sc2_q); op_b = 34'(apq_q); end
      jpcr_pkg::ST_NQ1:  begin op_a = 34'(cc_q);  op_b = 34'(aqq_q); end
      jpcr_pkg::ST_E_M0: begin op_a = 34'(c_q);   op_b = 34'(rd_p_q); end
      jpcr_pkg::ST_E_M1: begin op_a = 34'(s_q);   op_b = 34'(rd_q_q); end
      jpcr_pkg::ST_E_M2: begin op_a = 34'(s_q);   op_b = 34'(rd_p_q); end
      jpcr_pkg::ST_E_M3: begin op_a = 34'(c_q);   op_b = 34'(rd_q_q); end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_d = op_a * op_b;

  assign cdif = {apq_q, 1'b0};
  assign ddif = $signed({aqq_q[31], aqq_q}) - $signed({app_q[31], app_q});
  assign rot  = (mc_q >= 33'd65536) || (prod_q[63:0] > {33'b0, ddsh_q});
  assign sv_t = prod_q[63:0] + 64'd536870912;
  assign sv   = sv_t[61:30];

  assign sq_start  = (cmd_i.step == jpcr_pkg::ST_SQ1_GO) || (cmd_i.step == jpcr_pkg::ST_SQ2_GO);
  assign sq_arg    = (cmd_i.step == jpcr_pkg::ST_SQ1_GO) ? acc_q[63:0] + prod_q[63:0]
                                                         : 64'h1000_0000_0000_0000 + prod_q[63:0];
  assign div_start = (cmd_i.step == jpcr_pkg::ST_DIV1_GO) ||
                     (cmd_i.step == jpcr_pkg::ST_DIV2_GO);
  assign div_num   = (cmd_i.step == jpcr_pkg::ST_DIV1_GO)
                   ? {1'b0, mc_q, 30'b0} + {31'b0, u_q[33:1]}
                   : 64'h1000_0000_0000_0000 + {33'b0, sq_q[31:1]};
  assign div_den   = (cmd_i.step == jpcr_pkg::ST_DIV1_GO) ? u_q : {2'b0, sq_q};

  jpcr_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .arg_i   (sq_arg),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  jpcr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (cmd_i.step)
      jpcr_pkg::ST_BAD: begin
        c_q <= jpcr_pkg::ONE_Q30;
        s_q <= '0;
      end
      jpcr_pkg::ST_RD_Q: app_q <= rd_p_q;
      jpcr_pkg::ST_LOAD: begin
        apq_q <= rd_p_q;
        aqq_q <= rd_q_q;
      end
      jpcr_pkg::ST_DIFF: begin
        mc_q  <= cdif[32] ? 33'(-cdif) : cdif;
        md_q  <= ddif[32] ? 33'(-ddif) : ddif;
        neg_q <= cdif[32] ^ ddif[32];
      end
      jpcr_pkg::ST_MUL_CC: ddsh_q <= prod_q[63:33];
      jpcr_pkg::ST_TEST: begin
        if (!rot) begin
          c_q <= jpcr_pkg::ONE_Q30;
          s_q <= '0;
        end else if (mc_q[32] || mc_q[31] || md_q[32] || md_q[31]) begin
          mc_q <= mc_q >> 1;
          md_q <= md_q >> 1;
        end
      end
      jpcr_pkg::ST_MUL_D2: acc_q <= prod_q;
      jpcr_pkg::ST_SQ1_WT: if (sq_done) u_q <= {1'b0, md_q} + {2'b0, sq_root};
      jpcr_pkg::ST_DIV1_GO: begin
        if (u_q == '0) begin
          c_q <= jpcr_pkg::ONE_Q30;
          s_q <= '0;
        end
      end
      jpcr_pkg::ST_DIV1_WT: if (div_done) tm_q <= div_quo;
      jpcr_pkg::ST_SQ2_WT:  if (sq_done) sq_q <= sq_root;
      jpcr_pkg::ST_DIV2_WT: if (div_done) c_q <= $signed(div_quo);
      jpcr_pkg::ST_SV:   s_q   <= neg_q ? $signed(-sv) : $signed(sv);
      jpcr_pkg::ST_M_SS: cc_q  <= 32'(jpcr_pkg::rescale30(prod_q));
      jpcr_pkg::ST_M_SC: ss_q  <= 32'(jpcr_pkg::rescale30(prod_q));
      jpcr_pkg::ST_SC2:  sc2_q <= 32'(jpcr_pkg::rescale30(prod_q <<< 1));
      jpcr_pkg::ST_NP1:  acc_q <= prod_q;
      jpcr_pkg::ST_NP2:  acc_q <= acc_q - prod_q;
      jpcr_pkg::ST_NP3:  acc_q <= acc_q + prod_q;
      jpcr_pkg::ST_NQ0: begin
        newpp_q <= jpcr_pkg::sat32(jpcr_pkg::rescale30(acc_q));
        acc_q   <= prod_q;
      end
      jpcr_pkg::ST_NQ1: acc_q <= acc_q + prod_q;
      jpcr_pkg::ST_NQ2: acc_q <= acc_q + prod_q;
      jpcr_pkg::ST_NQ3: newqq_q <= jpcr_pkg::sat32(jpcr_pkg::rescale30(acc_q));
      jpcr_pkg::ST_E_M1: acc_q <= prod_q;
      jpcr_pkg::ST_E_M2: acc_q <= acc_q - prod_q;
      jpcr_pkg::ST_E_M3: begin
        pu_q  <= jpcr_pkg::sat32(jpcr_pkg::rescale30(acc_q));
        acc_q <= prod_q;
      end
      jpcr_pkg::ST_E_M4: acc_q <= acc_q + prod_q;
      jpcr_pkg::ST_E_OUT: begin
        // pivot rows get the new diagonals and zeroed off-diagonals
        if (cmd_i.ovr_p) begin
          p_updated_o <= newpp_q;
          q_updated_o <= '0;
        end else if (cmd_i.ovr_q) begin
          p_updated_o <= '0;
          q_updated_o <= newqq_q;
        end else begin
          p_updated_o <= pu_q;
          q_updated_o <= jpcr_pkg::sat32(jpcr_pkg::rescale30(acc_q));
        end
        cos_value_o   <= c_q;
        sin_value_o   <= s_q;
        row_index_o   <= cmd_i.row;
        bad_pair_o    <= cmd_i.bad;
        last_result_o <= cmd_i.last_row;
      end
      default: begin
      end
    endcase
  end

  assign status_o.rot      = rot;
  assign status_o.u_zero   = (u_q == '0);
  assign status_o.sq_done  = sq_done;
  assign status_o.div_done = div_done;

endmodule

[rtl/jpcr_ctrl.sv]
// ----------------------------------------------------------------------------
// jpcr_ctrl
// sequencer for loading, rotation solve and element emission
// ----------------------------------------------------------------------------
module jpcr_ctrl #(
  parameter int unsigned MAX_ROWS = jpcr_pkg::MAX_ROWS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [jpcr_pkg::IDX_W-1:0] p_index_i,
  input  logic [jpcr_pkg::IDX_W-1:0] q_index_i,
  input  logic                       last_item_i,
  output jpcr_pkg::cmd_t             cmd_o,
  input  jpcr_pkg::status_t          status_i,
  output logic                       result_strobe_o
);

  localparam int unsigned CW = $clog2(MAX_ROWS + 1);

  jpcr_pkg::step_e state_q, state_d;
  logic [CW-1:0] count_q, count_d, n_q, n_d, k_q, k_d, n_new;
  logic [jpcr_pkg::IDX_W-1:0] p_q, p_d, q_q, q_d;
  logic bad_q, bad_d, strobe_q, wr_ok, last_row;

  assign wr_ok    = (count_q < CW'(MAX_ROWS));
  assign n_new    = wr_ok ? CW'(count_q + 1'b1) : count_q;
  assign last_row = (CW'(k_q + 1'b1) == n_q);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    n_d     = n_q;
    k_d     = k_q;
    p_d     = p_q;
    q_d     = q_q;
    bad_d   = bad_q;

    cmd_o.step     = state_q;
    cmd_o.wr_en    = 1'b0;
    cmd_o.row      = 6'(k_q);
    cmd_o.ovr_p    = !bad_q && (8'(k_q) == 8'(p_q));
    cmd_o.ovr_q    = !bad_q && (8'(k_q) == 8'(q_q));
    cmd_o.bad      = bad_q;
    cmd_o.last_row = last_row;

    case (state_q)
      jpcr_pkg::ST_IDLE: begin
        cmd_o.row = 6'(count_q);
        if (start) begin
          cmd_o.wr_en = wr_ok;
          if (last_item_i) begin
            n_d     = n_new;
            p_d     = p_index_i;
            q_d     = q_index_i;
            bad_d   = (p_index_i >= q_index_i) || (8'(q_index_i) >= 8'(n_new));
            k_d     = '0;
            count_d = '0;
            state_d = ((p_index_i >= q_index_i) || (8'(q_index_i) >= 8'(n_new)))
                    ? jpcr_pkg::ST_BAD : jpcr_pkg::ST_RD_P;
          end else begin
            count_d = n_new;
          end
        end
      end
      jpcr_pkg::ST_BAD: state_d = jpcr_pkg::ST_E_RD;
      jpcr_pkg::ST_RD_P: begin
        cmd_o.row = p_q;
        state_d   = jpcr_pkg::ST_RD_Q;
      end
      jpcr_pkg::ST_RD_Q: begin
        cmd_o.row = q_q;
        state_d   = jpcr_pkg::ST_LOAD;
      end
      jpcr_pkg::ST_LOAD:   state_d = jpcr_pkg::ST_DIFF;
      jpcr_pkg::ST_DIFF:   state_d = jpcr_pkg::ST_MUL_DD;
      jpcr_pkg::ST_MUL_DD: state_d = jpcr_pkg::ST_MUL_CC;
      jpcr_pkg::ST_MUL_CC: state_d = jpcr_pkg::ST_TEST;
      jpcr_pkg::ST_TEST:   state_d = status_i.rot ? jpcr_pkg::ST_MUL_C2 : jpcr_pkg::ST_M_CC;
      jpcr_pkg::ST_MUL_C2: state_d = jpcr_pkg::ST_MUL_D2;
      jpcr_pkg::ST_MUL_D2: state_d = jpcr_pkg::ST_SQ1_GO;
      jpcr_pkg::ST_SQ1_GO: state_d = jpcr_pkg::ST_SQ1_WT;
      jpcr_pkg::ST_SQ1_WT: if (status_i.sq_done) state_d = jpcr_pkg::ST_DIV1_GO;
      jpcr_pkg::ST_DIV1_GO:
        state_d = status_i.u_zero ? jpcr_pkg::ST_M_CC : jpcr_pkg::ST_DIV1_WT;
      jpcr_pkg::ST_DIV1_WT: if (status_i.div_done) state_d = jpcr_pkg::ST_MUL_TM;
      jpcr_pkg::ST_MUL_TM:  state_d = jpcr_pkg::ST_SQ2_GO;
      jpcr_pkg::ST_SQ2_GO:  state_d = jpcr_pkg::ST_SQ2_WT;
      jpcr_pkg::ST_SQ2_WT:  if (status_i.sq_done) state_d = jpcr_pkg::ST_DIV2_GO;
      jpcr_pkg::ST_DIV2_GO: state_d = jpcr_pkg::ST_DIV2_WT;
      jpcr_pkg::ST_DIV2_WT: if (status_i.div_done) state_d = jpcr_pkg::ST_MUL_TC;
      jpcr_pkg::ST_MUL_TC:  state_d = jpcr_pkg::ST_SV;
      jpcr_pkg::ST_SV:      state_d = jpcr_pkg::ST_M_CC;
      jpcr_pkg::ST_M_CC:    state_d = jpcr_pkg::ST_M_SS;
      jpcr_pkg::ST_M_SS:    state_d = jpcr_pkg::ST_M_SC;
      jpcr_pkg::ST_M_SC:    state_d = jpcr_pkg::ST_SC2;
      jpcr_pkg::ST_SC2:     state_d = jpcr_pkg::ST_NP0;
      jpcr_pkg::ST_NP0:     state_d = jpcr_pkg::ST_NP1;
      jpcr_pkg::ST_NP1:     state_d = jpcr_pkg::ST_NP2;
      jpcr_pkg::ST_NP2:     state_d = jpcr_pkg::ST_NP3;
      jpcr_pkg::ST_NP3:     state_d = jpcr_pkg::ST_NQ0;
      jpcr_pkg::ST_NQ0:     state_d = jpcr_pkg::ST_NQ1;
      jpcr_pkg::ST_NQ1:     state_d = jpcr_pkg::ST_NQ2;
      jpcr_pkg::ST_NQ2:     state_d = jpcr_pkg::ST_NQ3;
      jpcr_pkg::ST_NQ3:     state_d = jpcr_pkg::ST_E_RD;
      jpcr_pkg::ST_E_RD:    state_d = jpcr_pkg::ST_E_M0;
      jpcr_pkg::ST_E_M0:    state_d = jpcr_pkg::ST_E_M1;
      jpcr_pkg::ST_E_M1:    state_d = jpcr_pkg::ST_E_M2;
      jpcr_pkg::ST_E_M2:    state_d = jpcr_pkg::ST_E_M3;
      jpcr_pkg::ST_E_M3:    state_d = jpcr_pkg::ST_E_M4;
      jpcr_pkg::ST_E_M4:    state_d = jpcr_pkg::ST_E_OUT;
      jpcr_pkg::ST_E_OUT: begin
        k_d     = CW'(k_q + 1'b1);
        state_d = last_row ? jpcr_pkg::ST_IDLE : jpcr_pkg::ST_E_RD;
      end
      default: state_d = jpcr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= jpcr_pkg::ST_IDLE;
      count_q  <= '0;
      n_q      <= '0;
      k_q      <= '0;
      p_q      <= '0;
      q_q      <= '0;
      bad_q    <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      n_q      <= n_d;
      k_q      <= k_d;
      p_q      <= p_d;
      q_q      <= q_d;
      bad_q    <= bad_d;
      strobe_q <= (state_q == jpcr_pkg::ST_E_OUT);
    end
  end

  assign busy            = (state_q != jpcr_pkg::ST_IDLE);
  assign result_strobe_o = strobe_q;

endmodule

[rtl/jacobi_pivot_column_rotation_core.sv]
// ----------------------------------------------------------------------------
// jacobi_pivot_column_rotation_core
// loads the p and q columns of a symmetric matrix, solves the 2x2 schur
// rotation at the pivot and streams out the rotated column pairs
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                 payload
// --------  ---------  ------------------------  ------------------------------
// load      in         start && !busy            p/q value, p/q index, last
// result    out        result_strobe_o (1 cycle) p/q updated, cos, sin, row,
//                                                bad pair, last result
//
// a word without the last mark is stored, while the store has room, and busy
// stays low; a last word starts a run: a rotation solve with two square roots
// and two divides on the shared units, skipped when the identity test holds,
// none for a bad pair; then each loaded row in turn passes through the
// single shared multiplier, each result word strobed the cycle after its row
// reset clears the load count and the sequencer; the column stores are not
// cleared, only rows written in the current run are ever read
// the receiver cannot stall: result_strobe_o marks each result word for exactly one cycle
//
module jacobi_pivot_column_rotation_core #(
  parameter int unsigned MAX_ROWS = jpcr_pkg::MAX_ROWS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [31:0]         p_value_i,
  input  logic signed [31:0]         q_value_i,
  input  logic [jpcr_pkg::IDX_W-1:0] p_index_i,
  input  logic [jpcr_pkg::IDX_W-1:0] q_index_i,
  input  logic                       last_item_i,
  output logic                       result_strobe_o,
  output logic signed [31:0]         p_updated_o,
  output logic signed [31:0]         q_updated_o,
  output logic signed [31:0]         cos_value_o,
  output logic signed [31:0]         sin_value_o,
  output logic [jpcr_pkg::IDX_W-1:0] row_index_o,
  output logic                       bad_pair_o,
  output logic                       last_result_o
);

  // sequencer commands and datapath status
  jpcr_pkg::cmd_t    cmd;
  jpcr_pkg::status_t status;

  jpcr_ctrl #(
    .MAX_ROWS (MAX_ROWS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .p_index_i       (p_index_i),
    .q_index_i       (q_index_i),
    .last_item_i     (last_item_i),
    .cmd_o           (cmd),
    .status_i        (status),
    .result_strobe_o (result_strobe_o)
  );

  // stores, solve units and the multiply-accumulate path
  jpcr_datapath #(
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .p_value_i     (p_value_i),
    .q_value_i     (q_value_i),
    .p_updated_o   (p_updated_o),
    .q_updated_o   (q_updated_o),
    .cos_value_o   (cos_value_o),
    .sin_value_o   (sin_value_o),
    .row_index_o   (row_index_o),
    .bad_pair_o    (bad_pair_o),
    .last_result_o (last_result_o)
  );

endmodule

[tb/tb_jacobi_pivot_column_rotation_core.sv]
// ----------------------------------------------------------------------------
// tb_jacobi_pivot_column_rotation_core
// loads column sets of random and corner-case content, predicts every rotated
// row word with a bit-exact model of the schur rotation and checks the stream
// ----------------------------------------------------------------------------
module tb_jacobi_pivot_column_rotation_core;

  localparam int IW         = jpcr_pkg::IDX_W;
  localparam int ROWS       = 64;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 600;

  // one expected row word
  typedef struct {
    logic signed [31:0] p_upd;
    logic signed [31:0] q_upd;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
    logic [IW-1:0]      row;
    logic               bad;
    logic               last;
  } row_word_t;

  // rotation predictor and queue of pending row words
  class rotation_board;
    logic signed [31:0] p_col[ROWS];
    logic signed [31:0] q_col[ROWS];
    int                 n_loaded;
    row_word_t          pending[$];
    int                 runs;
    int                 bad_runs;

    function new();
      n_loaded = 0;
      runs     = 0;
      bad_runs = 0;
    endfunction

    static function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // floor(x / 2^30 + 1/2)
    static function longint round30(longint x);
      return (x + (64'sd1 <<< 29)) >>> 30;
    endfunction

    static function longint clip32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    static function void schur_cs(longint app, longint apq, longint aqq,
                                  output longint c, output longint s);
      longint          cc, dd;
      longint unsigned mc, md, r, u, tm, sq, cv, sv;
      bit              rot;
      cc = 2 * apq;
      dd = aqq - app;
      mc = (cc < 0) ? -cc : cc;
      md = (dd < 0) ? -dd : dd;
      rot = (mc >= 65536) || (mc * mc > ((md * md) >> 33));
      c = 64'sd1 <<< 30;
      s = 0;
      if (!rot) return;
      if (mc >= (64'd1 << 31) || md >= (64'd1 << 31)) begin
        mc >>= 1;
        md >>= 1;
      end
      r = int_sqrt(mc * mc + md * md);
      u = md + r;
      if (u == 0) return;
      tm = ((mc << 30) + (u >> 1)) / u;
      sq = int_sqrt((64'd1 << 60) + tm * tm);
      cv = ((64'd1 << 60) + (sq >> 1)) / sq;
      sv = (tm * cv + (64'd1 << 29)) >> 30;
      c = cv;
      s = ((cc < 0) != (dd < 0)) ? -longint'(sv) : longint'(sv);
    endfunction

    // an accepted load word
    function void note_word(logic signed [31:0] pv, logic signed [31:0] qv,
                            logic [IW-1:0] pi, logic [IW-1:0] qi, logic last);
      longint    c, s, npp, nqq, app, apq, aqq, ccq, ssq, sc2, pu, qu;
      bit        bad;
      row_word_t w;
      if (n_loaded < ROWS) begin
        p_col[n_loaded] = pv;
        q_col[n_loaded] = qv;
        n_loaded++;
      end
      if (!last) return;
      bad = (pi >= qi) || (qi >= n_loaded);
      c = 64'sd1 <<< 30;
      s = 0;
      npp = 0;
      nqq = 0;
      if (!bad) begin
        app = p_col[pi];
        apq = p_col[qi];
        aqq = q_col[qi];
        schur_cs(app, apq, aqq, c, s);
        ccq = round30(c * c);
        ssq = round30(s * s);
        sc2 = round30(2 * s * c);
        npp = clip32(round30(ccq * app - sc2 * apq + ssq * aqq));
        nqq = clip32(round30(ssq * app + sc2 * apq + ccq * aqq));
      end
      for (int k = 0; k < n_loaded; k++) begin
        pu = clip32(round30(c * longint'(p_col[k]) - s * longint'(q_col[k])));
        qu = clip32(round30(s * longint'(p_col[k]) + c * longint'(q_col[k])));
        if (!bad && k == pi) begin
          pu = npp;
          qu = 0;
        end
        if (!bad && k == qi) begin
          pu = 0;
          qu = nqq;
        end
        w.p_upd = pu[31:0];
        w.q_upd = qu[31:0];
        w.cos_v = c[31:0];
        w.sin_v = s[31:0];
        w.row   = k[IW-1:0];
        w.bad   = bad;
        w.last  = (k + 1 == n_loaded);
        pending.push_back(w);
      end
      runs++;
      if (bad) bad_runs++;
      n_loaded = 0;
    endfunction

    // returns an empty string on a match, else a description
    function string check_word(row_word_t got);
      row_word_t e;
      string     msg;
      if (pending.size() == 0) return "row word with nothing pending";
      e = pending.pop_front();
      msg = "";
      if (got.p_upd !== e.p_upd) msg = {msg, $sformatf(" p_upd %h/%h", got.p_upd, e.p_upd)};
      if (got.q_upd !== e.q_upd) msg = {msg, $sformatf(" q_upd %h/%h", got.q_upd, e.q_upd)};
      if (got.cos_v !== e.cos_v) msg = {msg, $sformatf(" cos %h/%h", got.cos_v, e.cos_v)};
      if (got.sin_v !== e.sin_v) msg = {msg, $sformatf(" sin %h/%h", got.sin_v, e.sin_v)};
      if (got.row !== e.row) msg = {msg, $sformatf(" row %0d/%0d", got.row, e.row)};
      if (got.bad !== e.bad) msg = {msg, $sformatf(" bad %b/%b", got.bad, e.bad)};
      if (got.last !== e.last) msg = {msg, $sformatf(" last %b/%b", got.last, e.last)};
      if (msg != "") msg = {$sformatf("row %0d:", e.row), msg};
      return msg;
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic signed [31:0] p_value_i;
  logic signed [31:0] q_value_i;
  logic [IW-1:0]      p_index_i;
  logic [IW-1:0]      q_index_i;
  logic               last_item_i;
  logic               result_strobe_o;
  logic signed [31:0] p_updated_o;
  logic signed [31:0] q_updated_o;
  logic signed [31:0] cos_value_o;
  logic signed [31:0] sin_value_o;
  logic [IW-1:0]      row_index_o;
  logic               bad_pair_o;
  logic               last_result_o;

  rotation_board board;
  int            errors;
  int            words_in;
  int            words_out;
  int            idle_cycles;
  int            burst_left;

  jacobi_pivot_column_rotation_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .p_value_i      (p_value_i),
    .q_value_i      (q_value_i),
    .p_index_i      (p_index_i),
    .q_index_i      (q_index_i),
    .last_item_i    (last_item_i),
    .result_strobe_o(result_strobe_o),
    .p_updated_o    (p_updated_o),
    .q_updated_o    (q_updated_o),
    .cos_value_o    (cos_value_o),
    .sin_value_o    (sin_value_o),
    .row_index_o    (row_index_o),
    .bad_pair_o     (bad_pair_o),
    .last_result_o  (last_result_o)
  );

  // 12 unit clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // result side: the block cannot be held off, check every strobed word
  always @(posedge clk_i) begin
    row_word_t got;
    string     msg;
    if (rst_ni && result_strobe_o) begin
      got.p_upd = p_updated_o;
      got.q_upd = q_updated_o;
      got.cos_v = cos_value_o;
      got.sin_v = sin_value_o;
      got.row   = row_index_o;
      got.bad   = bad_pair_o;
      got.last  = last_result_o;
      msg = board.check_word(got);
      if (msg != "") report(msg);
      words_out++;
    end
  end

  // watchdog: cycles with no word moving either way
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_strobe_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("watchdog expired, %0d words pending", board.pending.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // element values: 0 full range, 1 small, 2 extremes
  function automatic logic signed [31:0] pick_value(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(2097152)) - 32'sd1048576;
      default: begin
        case ($urandom_range(3))
          0: return 32'sh7fff_ffff;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
    endcase
  endfunction

  // sender pacing: bursts of random length with random gaps
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(20, 1);
    gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
    if (gap > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // one load word, held until the block takes it
  task automatic send_word(logic signed [31:0] pv, logic signed [31:0] qv,
                           logic [IW-1:0] pi, logic [IW-1:0] qi, logic last);
    @(negedge clk_i);
    start       = 1'b1;
    p_value_i   = pv;
    q_value_i   = qv;
    p_index_i   = pi;
    q_index_i   = qi;
    last_item_i = last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note_word(pv, qv, pi, qi, last);
    words_in++;
    pace();
  endtask

  // a column set of n pairs, the pivot indices riding on the last word
  task automatic send_set(int n, int pi, int qi, int mode);
    for (int k = 0; k < n; k++) begin
      if (k == n - 1)
        send_word(pick_value(mode), pick_value(mode), IW'(pi), IW'(qi), 1'b1);
      else
        send_word(pick_value(mode), pick_value(mode), IW'($urandom), IW'($urandom), 1'b0);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start = 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  initial begin
    int n, pi, qi;
    board       = new();
    errors      = 0;
    words_in    = 0;
    words_out   = 0;
    idle_cycles = 0;
    burst_left  = 0;
    start       = 1'b0;
    p_value_i   = '0;
    q_value_i   = '0;
    p_index_i   = '0;
    q_index_i   = '0;
    last_item_i = 1'b0;
    rst_ni      = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: general rotation
    send_word(32'sd16777216, 32'sd3000000, 6'd0, 6'd0, 1'b0);
    send_word(-32'sd5000000, 32'sd700000, 6'd0, 6'd0, 1'b0);
    send_word(32'sd123456, -32'sd2000000, 6'd0, 6'd0, 1'b0);
    send_word(32'sd8000000, 32'sd33554432, 6'd0, 6'd3, 1'b1);
    // zero off-diagonal gives the identity rotation
    send_word(32'sh7fff_ffff, 32'sd0, 6'd0, 6'd0, 1'b0);
    send_word(32'sd5, -32'sd9, 6'd0, 6'd0, 1'b0);
    send_word(32'sd0, 32'sh8000_0000, 6'd0, 6'd2, 1'b1);
    // extreme elements, saturation in the rotated rows
    send_word(32'sh8000_0000, 32'sh7fff_ffff, 6'h3f, 6'h3f, 1'b0);
    send_word(32'sh7fff_ffff, 32'sh8000_0000, 6'h3f, 6'h3f, 1'b0);
    send_word(32'sh7fff_ffff, 32'sh7fff_ffff, 6'd1, 6'd2, 1'b1);
    // bad pair, p not below q
    send_word(32'sd1000, 32'sd2000, 6'd0, 6'd0, 1'b0);
    send_word(32'sd3000, 32'sd4000, 6'd1, 6'd1, 1'b1);
    // bad pair, q beyond the loaded rows
    send_word(-32'sd1000, 32'sd77, 6'd0, 6'd0, 1'b0);
    send_word(32'sd4096, -32'sd4096, 6'd0, 6'd5, 1'b1);
    // a single last word
    send_word(32'sh8000_0000, 32'sh8000_0000, 6'd0, 6'd0, 1'b1);
    // hold off until the stream has drained
    wait_drained();

    // store full: pairs past the last row are dropped
    for (int k = 0; k < ROWS + 3; k++)
      send_word(pick_value(k % 3), pick_value(1), IW'($urandom), IW'($urandom), 1'b0);
    send_word(pick_value(0), pick_value(0), 6'd10, 6'd63, 1'b1);

    // random sets: mostly well formed pivots, some bad ones
    while (words_in < 150) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(ROWS, 9) : $urandom_range(8, 1);
      if ($urandom_range(5) == 0) begin
        pi = $urandom_range(63);
        qi = $urandom_range(63);
      end else if (n >= 2) begin
        qi = $urandom_range(n - 1, 1);
        pi = $urandom_range(qi - 1);
      end else begin
        pi = 0;
        qi = 0;
      end
      send_set(n, pi, qi, $urandom_range(2));
    end

    wait_drained();
    $display("%0d load words in, %0d row words out, %0d runs (%0d bad pair)",
             words_in, words_out, board.runs, board.bad_runs);
    $display("covered identity, saturating, bad pivot and full store runs");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/jpcr_pkg.sv
rtl/jpcr_isqrt.sv
rtl/jpcr_div.sv
rtl/jpcr_datapath.sv
rtl/jpcr_ctrl.sv
rtl/jacobi_pivot_column_rotation_core.sv
tb/tb_jacobi_pivot_column_rotation_core.sv
